### rtl/core/tad_pkg.sv
// Shared types, codes and constants for the threshold alarm debouncer.
package tad_pkg;

    // Request kinds
    localparam logic [1:0] KIND_TEMP  = 2'd0;
    localparam logic [1:0] KIND_MOIST = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Grades and confirmed levels
    localparam logic [1:0] LVL_OK   = 2'd0;
    localparam logic [1:0] LVL_WARN = 2'd1;
    localparam logic [1:0] LVL_CRIT = 2'd2;

    // Causes
    localparam logic [1:0] WHY_CLEAR = 2'd0;
    localparam logic [1:0] WHY_THIGH = 2'd1;
    localparam logic [1:0] WHY_TLOW  = 2'd2;
    localparam logic [1:0] WHY_MLOW  = 2'd3;

    // Alarm events
    localparam logic [1:0] ALARM_NONE      = 2'd0;
    localparam logic [1:0] ALARM_WARN_BEEP = 2'd1;
    localparam logic [1:0] ALARM_CRIT      = 2'd2;
    localparam logic [1:0] ALARM_CLEAR     = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_TEMP_LOW_CRIT  = 3'd0;
    localparam logic [2:0] REG_TEMP_HIGH_CRIT = 3'd1;
    localparam logic [2:0] REG_TEMP_LOW_WARN  = 3'd2;
    localparam logic [2:0] REG_TEMP_HIGH_WARN = 3'd3;
    localparam logic [2:0] REG_MOIST_LOW_CRIT = 3'd4;
    localparam logic [2:0] REG_MOIST_LOW_WARN = 3'd5;
    localparam logic [2:0] REG_WARN_CONFIRM   = 3'd6;
    localparam logic [2:0] REG_CRIT_CONFIRM   = 3'd7;

    localparam logic [3:0]  CRIT_FLASH_TICKS  = 4'd5;
    localparam logic [3:0]  LCD_REFRESH_TICKS = 4'd10;
    localparam logic [3:0]  LCD_ELAPSED_MAX   = 4'd15;
    localparam logic [15:0] TIMER_MAX         = 16'hFFFF;
    localparam logic [9:0]  MOIST_MAX         = 10'd1000;

    typedef struct packed {
        logic signed [11:0] temp_low_crit;
        logic signed [11:0] temp_high_crit;
        logic signed [11:0] temp_low_warn;
        logic signed [11:0] temp_high_warn;
        logic [9:0]         moist_low_crit;
        logic [9:0]         moist_low_warn;
        logic [15:0]        warn_confirm;
        logic [15:0]        crit_confirm;
    } cfg_t;

    typedef struct packed {
        logic [1:0] temp_grade;
        logic [1:0] temp_why;
        logic [1:0] moist_grade;
        logic [1:0] moist_why;
        logic [1:0] next_level;
        logic [1:0] next_why;
    } grade_t;

    typedef struct packed {
        logic [1:0] level;
        logic [1:0] cause;
        logic [1:0] temp_grade;
        logic [1:0] moist_grade;
        logic       level_changed;
        logic [2:0] cause_flags;
        logic [1:0] alarm_code;
        logic       lcd_refresh;
        logic       flash_on;
    } result_t;

endpackage

### rtl/core/tad_grade.sv
// Threshold grading of the latest samples and selection of the candidate level.
module tad_grade (
    input  tad_pkg::cfg_t      cfg,
    input  logic               temp_present,
    input  logic signed [11:0] temp_latest,
    input  logic               moist_present,
    input  logic [9:0]         moist_latest,
    output tad_pkg::grade_t    grade
);

    always_comb begin
        grade = '0;
        grade.temp_grade  = tad_pkg::LVL_OK;
        grade.temp_why    = tad_pkg::WHY_CLEAR;
        grade.moist_grade = tad_pkg::LVL_OK;
        grade.moist_why   = tad_pkg::WHY_CLEAR;

        // First match wins, critical tests before warning tests
        if (temp_present) begin
            if (temp_latest <= cfg.temp_low_crit) begin
                grade.temp_grade = tad_pkg::LVL_CRIT;
                grade.temp_why   = tad_pkg::WHY_TLOW;
            end else if (temp_latest >= cfg.temp_high_crit) begin
                grade.temp_grade = tad_pkg::LVL_CRIT;
                grade.temp_why   = tad_pkg::WHY_THIGH;
            end else if (temp_latest <= cfg.temp_low_warn) begin
                grade.temp_grade = tad_pkg::LVL_WARN;
                grade.temp_why   = tad_pkg::WHY_TLOW;
            end else if (temp_latest >= cfg.temp_high_warn) begin
                grade.temp_grade = tad_pkg::LVL_WARN;
                grade.temp_why   = tad_pkg::WHY_THIGH;
            end
        end

        if (moist_present) begin
            if (moist_latest <= cfg.moist_low_crit) begin
                grade.moist_grade = tad_pkg::LVL_CRIT;
                grade.moist_why   = tad_pkg::WHY_MLOW;
            end else if (moist_latest <= cfg.moist_low_warn) begin
                grade.moist_grade = tad_pkg::LVL_WARN;
                grade.moist_why   = tad_pkg::WHY_MLOW;
            end
        end

        // Worst grade wins; temperature takes ties
        if (grade.temp_grade >= grade.moist_grade) begin
            grade.next_level = grade.temp_grade;
            grade.next_why   = grade.temp_why;
        end else begin
            grade.next_level = grade.moist_grade;
            grade.next_why   = grade.moist_why;
        end
        if (grade.next_level == tad_pkg::LVL_OK) begin
            grade.next_why = tad_pkg::WHY_CLEAR;
        end
    end

endmodule

### rtl/core/tad_eval.sv
// Sample store, confirmation debounce, alarm events and display pacing.
module tad_eval (
    input  logic              aclk,
    input  logic              aresetn,
    input  tad_pkg::cfg_t     cfg,
    input  logic              step,
    input  logic [1:0]        kind,
    input  logic signed [11:0] sample,
    output tad_pkg::result_t  result
);

    logic               temp_present_reg;
    logic               moist_present_reg;
    logic signed [11:0] temp_latest_reg;
    logic [9:0]         moist_latest_reg;
    logic [1:0]         level_reg, level_next;
    logic [1:0]         cause_reg, cause_next;
    logic               warn_pending_reg, warn_pending_next;
    logic [15:0]        warn_elapsed_reg, warn_elapsed_next;
    logic               crit_pending_reg, crit_pending_next;
    logic [15:0]        crit_elapsed_reg, crit_elapsed_next;
    logic [3:0]         lcd_elapsed_reg, lcd_elapsed_next;
    logic               flash_phase_reg, flash_phase_next;

    tad_pkg::grade_t    grade;
    logic [9:0]         moist_clamped;
    logic               changed;
    logic [3:0]         lcd_count;

    tad_grade u_grade (
        .cfg           (cfg),
        .temp_present  (temp_present_reg),
        .temp_latest   (temp_latest_reg),
        .moist_present (moist_present_reg),
        .moist_latest  (moist_latest_reg),
        .grade         (grade)
    );

    always_comb begin
        if (sample < 12'sd0) begin
            moist_clamped = '0;
        end else if (sample > $signed({2'b00, tad_pkg::MOIST_MAX})) begin
            moist_clamped = tad_pkg::MOIST_MAX;
        end else begin
            moist_clamped = sample[9:0];
        end
    end

    always_comb begin
        level_next         = level_reg;
        cause_next         = cause_reg;
        warn_pending_next  = warn_pending_reg;
        warn_elapsed_next  = warn_elapsed_reg;
        crit_pending_next  = crit_pending_reg;
        crit_elapsed_next  = crit_elapsed_reg;
        lcd_elapsed_next   = lcd_elapsed_reg;
        flash_phase_next   = flash_phase_reg;
        changed            = 1'b0;
        lcd_count          = lcd_elapsed_reg;
        result             = '0;

        // Age running timers first
        if (warn_pending_reg && warn_elapsed_reg != tad_pkg::TIMER_MAX) begin
            warn_elapsed_next = warn_elapsed_reg + 16'd1;
        end
        if (crit_pending_reg && crit_elapsed_reg != tad_pkg::TIMER_MAX) begin
            crit_elapsed_next = crit_elapsed_reg + 16'd1;
        end

        if (grade.next_level != level_reg) begin
            if (grade.next_level == tad_pkg::LVL_WARN) begin
                if (!warn_pending_reg) begin
                    warn_pending_next = 1'b1;
                    warn_elapsed_next = '0;
                end
                if (warn_elapsed_next >= cfg.warn_confirm) begin
                    level_next        = grade.next_level;
                    cause_next        = grade.next_why;
                    changed           = 1'b1;
                    warn_pending_next = 1'b0;
                    warn_elapsed_next = '0;
                end
            end else if (grade.next_level == tad_pkg::LVL_CRIT) begin
                if (!crit_pending_reg) begin
                    crit_pending_next = 1'b1;
                    crit_elapsed_next = '0;
                end
                if (crit_elapsed_next >= cfg.crit_confirm) begin
                    level_next        = grade.next_level;
                    cause_next        = grade.next_why;
                    changed           = 1'b1;
                    crit_pending_next = 1'b0;
                    crit_elapsed_next = '0;
                end
            end else begin
                // Back to ok at once; drop both timers
                level_next        = grade.next_level;
                cause_next        = grade.next_why;
                changed           = 1'b1;
                warn_pending_next = 1'b0;
                warn_elapsed_next = '0;
                crit_pending_next = 1'b0;
                crit_elapsed_next = '0;
            end
        end else begin
            if (grade.next_level == tad_pkg::LVL_WARN) begin
                if (!warn_pending_reg) begin
                    warn_pending_next = 1'b1;
                    warn_elapsed_next = '0;
                end
            end else begin
                warn_pending_next = 1'b0;
                warn_elapsed_next = '0;
            end
            if (grade.next_level == tad_pkg::LVL_CRIT) begin
                if (!crit_pending_reg) begin
                    crit_pending_next = 1'b1;
                    crit_elapsed_next = '0;
                end
            end else begin
                crit_pending_next = 1'b0;
                crit_elapsed_next = '0;
            end
        end

        if (lcd_elapsed_reg != tad_pkg::LCD_ELAPSED_MAX) begin
            lcd_count = lcd_elapsed_reg + 4'd1;
        end
        lcd_elapsed_next = lcd_count;
        if (level_next == tad_pkg::LVL_CRIT) begin
            if (lcd_count >= tad_pkg::CRIT_FLASH_TICKS) begin
                flash_phase_next   = ~flash_phase_reg;
                result.lcd_refresh = 1'b1;
                lcd_elapsed_next   = '0;
            end
        end else if (lcd_count >= tad_pkg::LCD_REFRESH_TICKS) begin
            flash_phase_next   = 1'b0;
            result.lcd_refresh = 1'b1;
            lcd_elapsed_next   = '0;
        end

        result.level         = level_next;
        result.cause         = cause_next;
        result.temp_grade    = grade.temp_grade;
        result.moist_grade   = grade.moist_grade;
        result.level_changed = changed;
        result.flash_on      = (level_next == tad_pkg::LVL_CRIT) ? flash_phase_next : 1'b0;
        result.alarm_code    = tad_pkg::ALARM_NONE;
        if (changed) begin
            if (level_reg == tad_pkg::LVL_CRIT && level_next != tad_pkg::LVL_CRIT) begin
                result.alarm_code = tad_pkg::ALARM_CLEAR;
            end else if (level_next == tad_pkg::LVL_CRIT) begin
                result.alarm_code = tad_pkg::ALARM_CRIT;
            end else if (level_next == tad_pkg::LVL_WARN) begin
                result.alarm_code = tad_pkg::ALARM_WARN_BEEP;
            end
            if (grade.temp_grade != tad_pkg::LVL_OK) begin
                result.cause_flags[0] = (grade.temp_why == tad_pkg::WHY_THIGH);
                result.cause_flags[1] = (grade.temp_why == tad_pkg::WHY_TLOW);
            end
            result.cause_flags[2] = (grade.moist_grade != tad_pkg::LVL_OK);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_present_reg  <= 1'b0;
            moist_present_reg <= 1'b0;
            temp_latest_reg   <= '0;
            moist_latest_reg  <= '0;
            level_reg         <= tad_pkg::LVL_OK;
            cause_reg         <= tad_pkg::WHY_CLEAR;
            warn_pending_reg  <= 1'b0;
            warn_elapsed_reg  <= '0;
            crit_pending_reg  <= 1'b0;
            crit_elapsed_reg  <= '0;
            lcd_elapsed_reg   <= tad_pkg::LCD_ELAPSED_MAX;
            flash_phase_reg   <= 1'b0;
        end else if (step) begin
            case (kind)
                tad_pkg::KIND_TEMP: begin
                    temp_latest_reg  <= sample;
                    temp_present_reg <= 1'b1;
                end
                tad_pkg::KIND_MOIST: begin
                    moist_latest_reg  <= moist_clamped;
                    moist_present_reg <= 1'b1;
                end
                tad_pkg::KIND_TICK: begin
                    level_reg        <= level_next;
                    cause_reg        <= cause_next;
                    warn_pending_reg <= warn_pending_next;
                    warn_elapsed_reg <= warn_elapsed_next;
                    crit_pending_reg <= crit_pending_next;
                    crit_elapsed_reg <= crit_elapsed_next;
                    lcd_elapsed_reg  <= lcd_elapsed_next;
                    flash_phase_reg  <= flash_phase_next;
                end
                default: begin
                    // Unused kind: hold everything
                end
            endcase
        end
    end

endmodule

### rtl/core/threshold_alarm_debouncer.sv
// Top level: configuration registers, request register, evaluation and result register.
//
// The block takes temperature samples, moisture samples and evaluation ticks on one
// valid/ready channel and answers every tick with one result; samples and the unused
// kind give none. A request is taken into an input register, evaluated by one pass of
// compare and counter logic, and a tick's result lands in an output register, so a
// request can be accepted every clock cycle unless a tick waits for room in the result
// register. A waiting result stalls the next tick and every request behind it; samples
// ahead of that tick keep flowing. Thresholds and confirm counts are written through the
// cfg_wr port; the user must write them only while no request is in flight, as the block
// does not enforce it. They come out of reset at their defaults.
module threshold_alarm_debouncer (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_wr_index,
    input  logic [15:0]        cfg_wr_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic signed [11:0] s_sample,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_level,
    output logic [1:0]         m_cause,
    output logic [1:0]         m_temp_grade,
    output logic [1:0]         m_moist_grade,
    output logic               m_level_changed,
    output logic [2:0]         m_cause_flags,
    output logic [1:0]         m_alarm_code,
    output logic               m_lcd_refresh,
    output logic               m_flash_on
);

    tad_pkg::cfg_t      cfg_reg;
    logic               in_valid_reg;
    logic [1:0]         in_kind_reg;
    logic signed [11:0] in_sample_reg;
    logic               out_valid_reg;
    tad_pkg::result_t   out_reg;
    tad_pkg::result_t   result;
    logic               out_free;
    logic               advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.temp_low_crit  <= 12'sd32;
            cfg_reg.temp_high_crit <= 12'sd560;
            cfg_reg.temp_low_warn  <= 12'sd80;
            cfg_reg.temp_high_warn <= 12'sd480;
            cfg_reg.moist_low_crit <= 10'd150;
            cfg_reg.moist_low_warn <= 10'd300;
            cfg_reg.warn_confirm   <= 16'd50;
            cfg_reg.crit_confirm   <= 16'd20;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                tad_pkg::REG_TEMP_LOW_CRIT:  cfg_reg.temp_low_crit  <= cfg_wr_data[11:0];
                tad_pkg::REG_TEMP_HIGH_CRIT: cfg_reg.temp_high_crit <= cfg_wr_data[11:0];
                tad_pkg::REG_TEMP_LOW_WARN:  cfg_reg.temp_low_warn  <= cfg_wr_data[11:0];
                tad_pkg::REG_TEMP_HIGH_WARN: cfg_reg.temp_high_warn <= cfg_wr_data[11:0];
                tad_pkg::REG_MOIST_LOW_CRIT: cfg_reg.moist_low_crit <= cfg_wr_data[9:0];
                tad_pkg::REG_MOIST_LOW_WARN: cfg_reg.moist_low_warn <= cfg_wr_data[9:0];
                tad_pkg::REG_WARN_CONFIRM:   cfg_reg.warn_confirm   <= cfg_wr_data;
                tad_pkg::REG_CRIT_CONFIRM:   cfg_reg.crit_confirm   <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // A tick needs room in the result register; other kinds never wait
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (in_kind_reg != tad_pkg::KIND_TICK || out_free);
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_kind_reg   <= s_kind;
            in_sample_reg <= s_sample;
        end
    end

    tad_eval u_eval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .step    (advance),
        .kind    (in_kind_reg),
        .sample  (in_sample_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_kind_reg == tad_pkg::KIND_TICK) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_kind_reg == tad_pkg::KIND_TICK) begin
            out_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_level         = out_reg.level;
    assign m_cause         = out_reg.cause;
    assign m_temp_grade    = out_reg.temp_grade;
    assign m_moist_grade   = out_reg.moist_grade;
    assign m_level_changed = out_reg.level_changed;
    assign m_cause_flags   = out_reg.cause_flags;
    assign m_alarm_code    = out_reg.alarm_code;
    assign m_lcd_refresh   = out_reg.lcd_refresh;
    assign m_flash_on      = out_reg.flash_on;

endmodule
